FILE: rtl/msd_pkg.sv
// package for the stereo downmix block: speaker position tables, register indexes and widths
// no dependencies; used by the top level, the divider and the checker

package msd_pkg;

    localparam int NUM_POS    = 18;
    localparam int POS_W      = 5;
    localparam int NUM_GROUPS = 12;
    localparam int GRP_W      = 4;
    localparam int WGT_W      = 6;
    localparam int GC_W       = 4;
    localparam int MASK_W     = 18;
    localparam int NCH_W      = 5;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd1;

    localparam logic [MASK_W-1:0] MASK_RESET = 18'd3;
    localparam logic [NCH_W-1:0]  NCH_RESET  = 5'd2;

    // left weight in [5:3], right weight in [2:0], both in quarters
    function automatic logic [WGT_W-1:0] pos_weight(input logic [POS_W-1:0] pos);
        logic [WGT_W-1:0] w;
        case (pos)
            5'd0:    w = 6'o40;
            5'd1:    w = 6'o04;
            5'd2:    w = 6'o22;
            5'd3:    w = 6'o22;
            5'd4:    w = 6'o40;
            5'd5:    w = 6'o04;
            5'd6:    w = 6'o31;
            5'd7:    w = 6'o13;
            5'd8:    w = 6'o22;
            5'd9:    w = 6'o40;
            5'd10:   w = 6'o04;
            5'd11:   w = 6'o22;
            5'd12:   w = 6'o31;
            5'd13:   w = 6'o22;
            5'd14:   w = 6'o13;
            5'd15:   w = 6'o40;
            5'd16:   w = 6'o22;
            5'd17:   w = 6'o04;
            default: w = 6'o00;
        endcase
        return w;
    endfunction

    function automatic logic [GRP_W-1:0] pos_group(input logic [POS_W-1:0] pos);
        logic [GRP_W-1:0] g;
        case (pos)
            5'd0, 5'd1:   g = 4'd0;
            5'd2:         g = 4'd1;
            5'd3:         g = 4'd2;
            5'd4, 5'd5:   g = 4'd3;
            5'd6, 5'd7:   g = 4'd4;
            5'd8:         g = 4'd5;
            5'd9, 5'd10:  g = 4'd6;
            5'd11:        g = 4'd7;
            5'd12, 5'd14: g = 4'd8;
            5'd13:        g = 4'd9;
            5'd15, 5'd17: g = 4'd10;
            5'd16:        g = 4'd11;
            default:      g = 4'd0;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/msd_div.sv
// restoring divider, one quotient bit per cycle, small unsigned divisor
// depends on msd_pkg for the divisor width

module msd_div #(
    parameter int DIV_W = 31
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIV_W-1:0]         dividend,
    input  logic [msd_pkg::GC_W-1:0] divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         quotient
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [GC_W-1:0]  rem_reg, rem_next;
    logic [GC_W-1:0]  dvs_reg, dvs_next;
    logic             done_reg, done_next;
    logic [GC_W:0]    trial;
    logic [GC_W:0]    diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so it fits the divisor width
            rem_next = ge ? diff[GC_W-1:0] : trial[GC_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/multichannel_stereo_downmix.sv
// multichannel to stereo downmix top level: slot weight derivation, shared multiply-add, finish
// depends on msd_pkg and msd_div

// After reset and after every write to channel_mask or num_channels the block walks the 18
// speaker positions twice (set bits, then clear bits) to build the slot weight table, with
// in_stall high. Each channel sample then takes an accept beat and one pass each for left
// and right through a single multiply-add unit. On the frame's last slot, left and right
// are each rounded and divided by 4 times the group count in a shared restoring divider
// that yields one quotient bit per cycle, and the stereo beat is then loaded into the
// output register. A waiting result does not hold up the next frame's samples; only a
// second finished frame waits for the output register to drain.

module multichannel_stereo_downmix #(
    parameter int MAX_SLOTS   = 18,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msd_pkg::CFG_W-1:0]     cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] channel_sample,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic signed [SAMPLE_BITS-1:0] left_sample,
    output logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          out_valid,
    input  logic                          out_stall
);
    import msd_pkg::*;

    localparam int ACC_W   = SAMPLE_BITS + 3 + $clog2(MAX_SLOTS + 1);
    localparam int DIV_W   = ACC_W - 1;
    localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);
    localparam int PROD_W  = SAMPLE_BITS + 4;

    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(64'd1 << (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [2:0] S_DERIVE = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MAC_L  = 3'd2;
    localparam logic [2:0] S_MAC_R  = 3'd3;
    localparam logic [2:0] S_ABS    = 3'd4;
    localparam logic [2:0] S_START  = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_HOLD   = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [MASK_W-1:0]       mask_reg, mask_next;
    logic [NCH_W-1:0]        nch_reg, nch_next;
    logic [WGT_W-1:0]        weights_reg [MAX_SLOTS];
    logic [WGT_W-1:0]        weights_next [MAX_SLOTS];
    logic                    pass_reg, pass_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SLOT_CW-1:0]      idx_reg, idx_next;
    logic [NUM_GROUPS-1:0]   groups_reg, groups_next;
    logic [GC_W-1:0]         gc_reg, gc_next;
    logic [NCH_W-1:0]        slot_reg, slot_next;
    logic signed [ACC_W-1:0] acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0] acc_r_reg, acc_r_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                    sel_reg, sel_next;
    logic                    neg_reg, neg_next;
    logic [ACC_W-1:0]        mag_reg, mag_next;
    logic [SAMPLE_BITS-1:0]  left_res_reg, left_res_next;
    logic [SAMPLE_BITS-1:0]  right_res_reg, right_res_next;
    logic [SAMPLE_BITS-1:0]  out_l_reg, out_l_next;
    logic [SAMPLE_BITS-1:0]  out_r_reg, out_r_next;
    logic                    out_valid_reg, out_valid_next;

    logic [NCH_W-1:0]        eff;
    logic [SLOT_CW-1:0]      limit;
    logic                    present;
    logic                    take;
    logic [GRP_W-1:0]        grp;
    logic [WGT_W-1:0]        slot_w;
    logic [2:0]              mac_w;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] mac_sum;
    logic                    last_slot;
    logic signed [ACC_W-1:0] fin_acc;
    logic [ACC_W:0]          rnd_sum;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_W-1:0]        quo;
    logic [DIV_W-1:0]        quo_neg;
    logic [SAMPLE_BITS-1:0]  sat_val;
    logic                    cfg_hit;

    assign eff   = (nch_reg == '0) ? NCH_W'(1) : nch_reg;
    assign limit = (eff > NCH_W'(MAX_SLOTS)) ? SLOT_CW'(MAX_SLOTS) : SLOT_CW'(eff);

    // derivation step: set bits on the first pass, clear bits on the second
    assign present = mask_reg[pos_reg];
    assign take    = (idx_reg < limit) && (present == !pass_reg);
    assign grp     = pos_group(pos_reg);

    // shared multiply-add, left weight on the first pass and right on the second
    assign slot_w    = (slot_reg < NCH_W'(MAX_SLOTS)) ? weights_reg[slot_reg[IDX_W-1:0]] : '0;
    assign mac_w     = (state_reg == S_MAC_L) ? slot_w[5:3] : slot_w[2:0];
    assign mac_acc   = (state_reg == S_MAC_L) ? acc_l_reg : acc_r_reg;
    assign prod      = $signed({1'b0, mac_w}) * smp_reg;
    assign mac_sum   = mac_acc + ACC_W'(prod);
    assign last_slot = ({1'b0, slot_reg} + (NCH_W + 1)'(1)) >= {1'b0, eff};

    // round half away from zero: (|acc| + 2*gc) / 4 / gc
    assign fin_acc = sel_reg ? acc_r_reg : acc_l_reg;
    assign rnd_sum = {1'b0, mag_reg} + (ACC_W + 1)'({gc_reg, 1'b0});

    msd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_sum[ACC_W:2]),
        .divisor  (gc_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign quo_neg = DIV_W'(0) - quo;

    always_comb
    begin
        if (!neg_reg)
            sat_val = (quo > POS_LIM) ? OUT_MAX : quo[SAMPLE_BITS-1:0];
        else
            sat_val = (quo > NEG_LIM) ? OUT_MIN : quo_neg[SAMPLE_BITS-1:0];
    end

    assign cfg_hit = cfg_write &&
                     (cfg_index == REG_CHANNEL_MASK || cfg_index == REG_NUM_CHANNELS);

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        nch_next       = nch_reg;
        weights_next   = weights_reg;
        pass_next      = pass_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        groups_next    = groups_reg;
        gc_next        = gc_reg;
        slot_next      = slot_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        smp_next       = smp_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        left_res_next  = left_res_reg;
        right_res_next = right_res_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_DERIVE:
            begin
                if (take)
                begin
                    weights_next[idx_reg[IDX_W-1:0]] = pos_weight(pos_reg);
                    idx_next = idx_reg + 1'b1;
                    if (!groups_reg[grp])
                    begin
                        groups_next[grp] = 1'b1;
                        gc_next = gc_reg + 1'b1;
                    end
                end
                if (pos_reg == POS_W'(NUM_POS - 1))
                begin
                    pos_next = '0;
                    if (pass_reg)
                    begin
                        state_next = S_IDLE;
                        if (gc_next == '0)
                            gc_next = GC_W'(1);
                    end
                    else
                    begin
                        pass_next = 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next   = channel_sample;
                    state_next = S_MAC_L;
                end
            end
            S_MAC_L:
            begin
                acc_l_next = mac_sum;
                state_next = S_MAC_R;
            end
            S_MAC_R:
            begin
                acc_r_next = mac_sum;
                if (last_slot)
                begin
                    sel_next   = 1'b0;
                    state_next = S_ABS;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ABS:
            begin
                neg_next   = fin_acc[ACC_W-1];
                mag_next   = fin_acc[ACC_W-1] ? ACC_W'(-fin_acc) : ACC_W'(fin_acc);
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!sel_reg)
                    begin
                        left_res_next = sat_val;
                        sel_next      = 1'b1;
                        state_next    = S_ABS;
                    end
                    else
                    begin
                        right_res_next = sat_val;
                        state_next     = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                // a previous beat may still sit in the output register
                if (!out_valid_reg || !out_stall)
                begin
                    out_l_next     = left_res_reg;
                    out_r_next     = right_res_reg;
                    out_valid_next = 1'b1;
                    acc_l_next     = '0;
                    acc_r_next     = '0;
                    slot_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_DERIVE;
            end
        endcase

        // register write rebuilds the table and restarts the frame
        if (cfg_hit)
        begin
            if (cfg_index == REG_CHANNEL_MASK)
                mask_next = cfg_data[MASK_W-1:0];
            else
                nch_next = cfg_data[NCH_W-1:0];
            for (int i = 0; i < MAX_SLOTS; i++)
                weights_next[i] = '0;
            pass_next   = 1'b0;
            pos_next    = '0;
            idx_next    = '0;
            groups_next = '0;
            gc_next     = '0;
            slot_next   = '0;
            acc_l_next  = '0;
            acc_r_next  = '0;
            state_next  = S_DERIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DERIVE;
            mask_reg      <= MASK_RESET;
            nch_reg       <= NCH_RESET;
            for (int i = 0; i < MAX_SLOTS; i++)
                weights_reg[i] <= '0;
            pass_reg      <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            groups_reg    <= '0;
            gc_reg        <= '0;
            slot_reg      <= '0;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            nch_reg       <= nch_next;
            weights_reg   <= weights_next;
            pass_reg      <= pass_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            groups_reg    <= groups_next;
            gc_reg        <= gc_next;
            slot_reg      <= slot_next;
            acc_l_reg     <= acc_l_next;
            acc_r_reg     <= acc_r_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg       <= smp_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        left_res_reg  <= left_res_next;
        right_res_reg <= right_res_next;
        out_l_reg     <= out_l_next;
        out_r_reg     <= out_r_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign left_sample  = out_l_reg;
    assign right_sample = out_r_reg;
    assign out_valid    = out_valid_reg;

endmodule

FILE: rtl/msd_check.sv
// port-level checks for the stereo downmix block, bound to the top level
// depends on msd_pkg for register indexes

module msd_check #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_write,
    input logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [SAMPLE_BITS-1:0]        left_sample,
    input logic [SAMPLE_BITS-1:0]        right_sample,
    input logic                          out_valid,
    input logic                          out_stall
);
    import msd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_sample) && $stable(right_sample))
        else $error("stalled output beat changed");

    // every sample keeps the block busy for its multiply-add passes
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back-to-back cycles");

    // a register write starts a table rebuild
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == REG_CHANNEL_MASK || cfg_index == REG_NUM_CHANNELS)
        |=> in_stall)
        else $error("input open right after register write");

    // results only come out of the finish sequence, never beside an input beat
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared outside the finish sequence");

endmodule

bind multichannel_stereo_downmix msd_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_msd_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
);

FILE: sim/tb_multichannel_stereo_downmix.sv
// testbench for multichannel_stereo_downmix: a directed table, then random frames under random
// settings, each stereo beat scored against an in-bench downmix predictor or a typed expected beat
// depends on msd_pkg and the rtl top level

module tb_multichannel_stereo_downmix;

    import msd_pkg::*;

    localparam int     MAX_SLOTS     = 18;
    localparam int     SAMPLE_BITS   = 24;
    localparam int     SETTLE_CYCLES = 120;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     HOLD_PHASE    = 5;
    localparam int     RANDOM_BEATS  = 2000;
    localparam int     LIMIT_TIME    = 6_000_000;
    localparam longint SAMPLE_MAX    = 2**(SAMPLE_BITS-1) - 1;
    localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t left_val;
        sample_t right_val;
    } stereo_beat_t;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] index;
        sample_t              value;
        logic [4:0]           count;
        logic                 typed;
        stereo_beat_t         typed_beat;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    sample_t              channel_sample;
    logic                 in_valid;
    logic                 in_stall;
    sample_t              left_sample;
    sample_t              right_sample;
    logic                 out_valid;
    logic                 out_stall;

    multichannel_stereo_downmix #(
        .MAX_SLOTS   (MAX_SLOTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .channel_sample (channel_sample),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_sample    (left_sample),
        .right_sample   (right_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

    always #2 clk = ~clk;

    // speaker position tables: left and right weight in quarters, depth group
    logic [2:0] pos_left_q  [NUM_POS] = '{4,0,2,2,4,0,3,1,2,4,0,2,3,2,1,4,2,0};
    logic [2:0] pos_right_q [NUM_POS] = '{0,4,2,2,0,4,1,3,2,0,4,2,1,2,3,0,2,4};
    logic [3:0] pos_group_q [NUM_POS] = '{0,0,1,2,3,3,4,4,5,6,6,7,8,9,8,10,11,10};

    // predictor state
    logic [MASK_W-1:0] mix_mask;
    logic [NCH_W-1:0]  mix_count;
    int                mix_slot;
    longint            mix_acc_l;
    longint            mix_acc_r;
    logic [2:0]        mix_wl [MAX_SLOTS];
    logic [2:0]        mix_wr [MAX_SLOTS];
    int                mix_groups;

    stereo_beat_t pending_mix [$];
    int           mismatch_count = 0;
    int           burst_left     = 0;
    bit           steady_sender  = 1'b0;
    bit           hold_off_req   = 1'b0;

    // walked top to bottom; typed rows carry a result readable straight off the setting
    localparam int PLAN_ROWS = 21;
    plan_row_t plan [PLAN_ROWS] = '{
        // reset setting: slot 0 is front left only, slot 1 front right only
        '{ROW_BEAT,  '0,               24'h7FFFFF, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h800000, 5'd1,  1'b1, '{24'h7FFFFF, 24'h800000}},
        '{ROW_BEAT,  '0,               24'h800000, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h7FFFFF, 5'd1,  1'b1, '{24'h800000, 24'h7FFFFF}},
        // a write to an unused index leaves the open frame alone
        '{ROW_BEAT,  '0,               24'h123456, 5'd1,  1'b0, '0},
        '{ROW_WRITE, REG_SPARE,        24'h03FFFF, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'hFFFFFB, 5'd1,  1'b1, '{24'h123456, 24'hFFFFFB}},
        // open frame dropped by the write, zero channels runs as one
        '{ROW_BEAT,  '0,               24'h000007, 5'd1,  1'b0, '0},
        '{ROW_WRITE, REG_NUM_CHANNELS, 24'h000000, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h7FFFFF, 5'd1,  1'b1, '{24'h7FFFFF, 24'h000000}},
        '{ROW_BEAT,  '0,               24'h800000, 5'd1,  1'b1, '{24'h800000, 24'h000000}},
        // one depth group with 3/1 weights: halfway cases both signs
        '{ROW_WRITE, REG_CHANNEL_MASK, 24'h0000C0, 5'd1,  1'b0, '0},
        '{ROW_WRITE, REG_NUM_CHANNELS, 24'h000002, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h000000, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h000002, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h000000, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'hFFFFFE, 5'd1,  1'b0, '0},
        // every position present, one slot past the table
        '{ROW_WRITE, REG_CHANNEL_MASK, 24'h03FFFF, 5'd1,  1'b0, '0},
        '{ROW_WRITE, REG_NUM_CHANNELS, 24'h000013, 5'd1,  1'b0, '0},
        '{ROW_BEAT,  '0,               24'h7FFFFF, 5'd18, 1'b0, '0},
        '{ROW_BEAT,  '0,               24'h800000, 5'd1,  1'b0, '0}
    };

    function automatic void restart_frame_model();
        mix_slot  = 0;
        mix_acc_l = 0;
        mix_acc_r = 0;
    endfunction

    function automatic void rebuild_slot_weights();
        int limit;
        int slot;
        int seen;
        limit = (mix_count == 0) ? 1 : int'(mix_count);
        if (limit > MAX_SLOTS)
            limit = MAX_SLOTS;
        slot = 0;
        seen = 0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            mix_wl[i] = '0;
            mix_wr[i] = '0;
        end
        // set positions take the first slots, clear ones fill the rest
        for (int pass = 0; pass < 2; pass++)
            for (int b = 0; b < NUM_POS; b++)
                if (slot < limit && mix_mask[b] == (pass == 0))
                begin
                    mix_wl[slot] = pos_left_q[b];
                    mix_wr[slot] = pos_right_q[b];
                    seen |= 1 << pos_group_q[b];
                    slot++;
                end
        mix_groups = $countones(seen);
        if (mix_groups == 0)
            mix_groups = 1;
    endfunction

    function automatic void reset_mix_model();
        mix_mask  = MASK_RESET;
        mix_count = NCH_RESET;
        restart_frame_model();
        rebuild_slot_weights();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] val);
        if (idx == REG_CHANNEL_MASK)
            mix_mask = val[MASK_W-1:0];
        else if (idx == REG_NUM_CHANNELS)
            mix_count = val[NCH_W-1:0];
        else
            return;
        rebuild_slot_weights();
        restart_frame_model();
    endfunction

    // divide by four per depth group, ties away from zero, then clamp
    function automatic sample_t scale_to_sample(input longint acc);
        longint d;
        longint q;
        d = 4 * mix_groups;
        if (acc >= 0)
            q = (acc + d / 2) / d;
        else
            q = -((-acc + d / 2) / d);
        if (q > SAMPLE_MAX)
            q = SAMPLE_MAX;
        if (q < SAMPLE_MIN)
            q = SAMPLE_MIN;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic bit mix_sample(input sample_t s, output stereo_beat_t mixed);
        int frame_len;
        frame_len = (mix_count == 0) ? 1 : int'(mix_count);
        mixed = '0;
        if (mix_slot < MAX_SLOTS)
        begin
            mix_acc_l += longint'(mix_wl[mix_slot]) * longint'(s);
            mix_acc_r += longint'(mix_wr[mix_slot]) * longint'(s);
        end
        if (mix_slot + 1 >= frame_len)
        begin
            mixed.left_val  = scale_to_sample(mix_acc_l);
            mixed.right_val = scale_to_sample(mix_acc_r);
            restart_frame_model();
            return 1'b1;
        end
        mix_slot++;
        return 1'b0;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0:       return sample_t'(SAMPLE_MAX);
            1:       return sample_t'(SAMPLE_MIN);
            2:       return sample_t'(int'($urandom_range(0, 16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {MASK_W{1'b1}};
            2:       return 18'd1 << $urandom_range(0, NUM_POS - 1);
            default: return CFG_W'($urandom_range(0, 2**MASK_W - 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_count();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = CFG_W'(1);
            2:       v = CFG_W'(MAX_SLOTS);
            3:       v = CFG_W'($urandom_range(MAX_SLOTS + 1, 31));
            default: v = CFG_W'($urandom_range(1, 8));
        endcase
        // stray high bits are dropped by the register
        if ($urandom_range(0, 3) == 0)
            v[CFG_W-1:NCH_W] = (CFG_W - NCH_W)'($urandom);
        return v;
    endfunction

    function automatic void flag_mismatch(input string what, input sample_t want,
                                          input sample_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s sample mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    task automatic let_block_settle();
        while (pending_mix.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        let_block_settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_register(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic offer_beat(input sample_t s, input logic typed, input stereo_beat_t typed_beat);
        stereo_beat_t mixed;
        if (!steady_sender)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
            end
            burst_left--;
        end
        in_valid       <= 1'b1;
        channel_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        if (mix_sample(s, mixed))
            pending_mix = {pending_mix, (typed ? typed_beat : mixed)};
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : score_beats
        stereo_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_mix.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: stereo beat with none expected: left %0d, right %0d",
                             $realtime, left_sample, right_sample);
            end
            else
            begin
                want = pending_mix[0];
                pending_mix.delete(0);
                if (left_sample !== want.left_val)
                    flag_mismatch("left", want.left_val, left_sample);
                if (right_sample !== want.right_val)
                    flag_mismatch("right", want.right_val, right_sample);
            end
        end
    end

    initial
    begin : receiver
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch   = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stretch == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                stretch = $urandom_range(10, 300);
            end
            stretch--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin : stimulus
        int phase;
        int frame_len;
        int beats_left;
        int random_beats_sent;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        channel_sample = '0;
        reset_mix_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_register(plan[i].index, plan[i].value[CFG_W-1:0]);
            else
                repeat (plan[i].count) offer_beat(plan[i].value, plan[i].typed,
                                                  plan[i].typed_beat);
        end

        phase             = 0;
        random_beats_sent = 0;
        while (random_beats_sent < RANDOM_BEATS)
        begin
            case (phase)
                0:
                begin
                    write_register(REG_CHANNEL_MASK, '0);
                    write_register(REG_NUM_CHANNELS, CFG_W'(31));
                end
                1:
                begin
                    write_register(REG_CHANNEL_MASK, {MASK_W{1'b1}});
                    write_register(REG_NUM_CHANNELS, CFG_W'(MAX_SLOTS));
                end
                2:
                    write_register(REG_NUM_CHANNELS, CFG_W'(1));
                HOLD_PHASE:
                begin
                    // one-sample frames against a parked output: the block must back up
                    write_register(REG_NUM_CHANNELS, CFG_W'(1));
                    hold_off_req  = 1'b1;
                    steady_sender = 1'b1;
                end
                default:
                begin
                    if ($urandom_range(0, 2) != 0)
                        write_register(REG_CHANNEL_MASK, random_mask());
                    if ($urandom_range(0, 2) != 0)
                        write_register(REG_NUM_CHANNELS, random_count());
                    if ($urandom_range(0, 19) == 0)
                        write_register(REG_SPARE, CFG_W'($urandom_range(0, 2**CFG_W - 1)));
                end
            endcase
            frame_len = (mix_count == 0) ? 1 : int'(mix_count);
            if (phase == HOLD_PHASE)
                beats_left = 24;
            else
                beats_left = frame_len * $urandom_range(1, (frame_len > 12) ? 3 : 10);
            // now and then leave a frame open for the next write to drop
            if (frame_len > 1 && $urandom_range(0, 5) == 0)
                beats_left += $urandom_range(1, frame_len - 1);
            repeat (beats_left)
            begin
                offer_beat(random_sample(), 1'b0, '0);
                random_beats_sent++;
            end
            steady_sender = 1'b0;
            phase++;
        end

        in_valid <= 1'b0;
        let_block_settle();
        if (mismatch_count == 0 && pending_mix.size() == 0)
            $display("** multichannel_stereo_downmix: PASSED **");
        else
            $display("** multichannel_stereo_downmix: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_TIME);
        $display("** multichannel_stereo_downmix: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/msd_pkg.sv
rtl/msd_div.sv
rtl/multichannel_stereo_downmix.sv
rtl/msd_check.sv
sim/tb_multichannel_stereo_downmix.sv
